[hw/rtl/r0ss_pkg.sv]
package r0ss_pkg;

  // field widths of the request and chunk transactions
  localparam int unsigned SECTOR_W   = 48;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned DSHIFT_W   = 2;
  localparam int unsigned SSHIFT_W   = 4;
  localparam int unsigned DISK_W     = 2;
  localparam int unsigned STRIPE_W   = 16;

  localparam logic [COUNT_W-1:0]  MAX_REQUEST_SECTORS = COUNT_W'(4032);
  localparam logic [SSHIFT_W-1:0] MIN_STRIPE_SHIFT    = SSHIFT_W'(6);
  localparam logic [DSHIFT_W-1:0] MIN_DISK_SHIFT      = DSHIFT_W'(1);
  localparam logic [DSHIFT_W-1:0] MAX_DISK_SHIFT      = DSHIFT_W'(2);

  // disk index masks for two and four disks
  localparam logic [DISK_W-1:0] DMASK_TWO  = DISK_W'(8'h01);
  localparam logic [DISK_W-1:0] DMASK_FOUR = DISK_W'(8'h03);

  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes, taken from paddr bit 2
  typedef enum logic {
    REG_DISK_SHIFT   = 1'b0,
    REG_STRIPE_SHIFT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                req_type;
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  sector_count;
  } req_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

[hw/rtl/r0ss_front.sv]
module r0ss_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,
  input  logic                        in_tuser,
  output r0ss_pkg::req_t              push_data,
  output logic                        push_valid,
  input  logic                        push_ready
);

  logic [r0ss_pkg::COUNT_W-1:0] count;

  assign count = in_tdata[59:48];

  // zero-count requests are taken and dropped
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && (count != '0);

  always_comb begin
    push_data.req_type     = in_tuser;
    push_data.start_sector = in_tdata[47:0];
    push_data.sector_count = (count > r0ss_pkg::MAX_REQUEST_SECTORS) ?
                             r0ss_pkg::MAX_REQUEST_SECTORS : count;
  end

endmodule

[hw/rtl/r0ss_queue.sv]
module r0ss_queue #(
  parameter int unsigned DEPTH = r0ss_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  r0ss_pkg::req_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output r0ss_pkg::req_t pop_data,
  output r0ss_pkg::hs_t  pop_hs_o,
  input  logic           pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  r0ss_pkg::req_t   entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready     = (count_r != CNT_W'(DEPTH));
  assign pop_hs_o.valid = (count_r != '0);
  assign pop_hs_o.ready = pop_ready;
  assign pop_data       = entries_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_hs_o.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/r0ss_back.sv]
module r0ss_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [r0ss_pkg::DSHIFT_W-1:0]     disk_shift,
  input  logic [r0ss_pkg::SSHIFT_W-1:0]     stripe_shift,
  input  r0ss_pkg::req_t                    pop_data,
  input  r0ss_pkg::hs_t                     pop_hs_i,
  output logic                              pop_ready,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [79:0]                       out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int unsigned SW = r0ss_pkg::SECTOR_W;
  localparam int unsigned CW = r0ss_pkg::COUNT_W;
  localparam int unsigned TW = r0ss_pkg::STRIPE_W;
  localparam int unsigned DW = r0ss_pkg::DISK_W;

  // chunk walker state
  logic                busy_r, busy_nxt;
  logic                type_r, type_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       remain_r, remain_nxt;
  logic [CW-1:0]       done_r, done_nxt;

  // output stage
  logic                ovalid_r, ovalid_nxt;
  logic                otype_r;
  logic [DW-1:0]       odisk_r;
  logic [SW-1:0]       osector_r;
  logic [CW-1:0]       olen_r;
  logic [CW-1:0]       ooffs_r;
  logic                olast_r;

  logic [r0ss_pkg::DSHIFT_W-1:0] ds;
  logic [r0ss_pkg::SSHIFT_W-1:0] ss;
  logic [DW-1:0]       dmask;
  logic [4:0]          hi_shift;
  logic [TW-1:0]       stripe_size, smask, offs, room;
  logic [SW-1:0]       stripe_hi, disk_sec;
  logic [DW-1:0]       stripe_no;
  logic [CW-1:0]       len;
  logic                last, step, take;

  always_comb begin
    ds = disk_shift;
    if (disk_shift < r0ss_pkg::MIN_DISK_SHIFT) ds = r0ss_pkg::MIN_DISK_SHIFT;
    if (disk_shift > r0ss_pkg::MAX_DISK_SHIFT) ds = r0ss_pkg::MAX_DISK_SHIFT;
    ss = (stripe_shift < r0ss_pkg::MIN_STRIPE_SHIFT) ? r0ss_pkg::MIN_STRIPE_SHIFT :
                                                       stripe_shift;
  end

  assign dmask       = (ds == r0ss_pkg::MIN_DISK_SHIFT) ? r0ss_pkg::DMASK_TWO :
                                                          r0ss_pkg::DMASK_FOUR;
  assign stripe_size = TW'(1) << ss;
  assign smask       = stripe_size - TW'(1);
  assign offs        = pos_r[TW-1:0] & smask;
  assign room        = stripe_size - offs;
  assign last        = (room >= TW'(remain_r));
  assign len         = last ? remain_r : room[CW-1:0];
  assign hi_shift    = 5'(ss) + 5'(ds);
  assign stripe_no   = DW'(pos_r >> ss);
  assign stripe_hi   = pos_r >> hi_shift;
  assign disk_sec    = (stripe_hi << ss) | SW'(offs);

  assign step      = busy_r && (!ovalid_r || out_tready);
  assign pop_ready = !busy_r || (step && last);
  assign take      = pop_hs_i.valid && pop_hs_i.ready;

  always_comb begin
    busy_nxt   = busy_r;
    type_nxt   = type_r;
    pos_nxt    = pos_r;
    remain_nxt = remain_r;
    done_nxt   = done_r;
    if (step) begin
      pos_nxt    = pos_r + SW'(len);
      remain_nxt = remain_r - len;
      done_nxt   = done_r + len;
      if (last) busy_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt   = 1'b1;
      type_nxt   = pop_data.req_type;
      pos_nxt    = pop_data.start_sector;
      remain_nxt = pop_data.sector_count;
      done_nxt   = '0;
    end
    ovalid_nxt = ovalid_r;
    if (step) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    pos_r    <= pos_nxt;
    remain_r <= remain_nxt;
    done_r   <= done_nxt;
    if (step) begin
      otype_r   <= type_r;
      odisk_r   <= stripe_no & dmask;
      osector_r <= disk_sec;
      olen_r    <= len;
      ooffs_r   <= done_r;
      olast_r   <= last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = otype_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'b0, ooffs_r, olen_r, osector_r, odisk_r};

endmodule

[hw/rtl/raid0_stripe_request_splitter_unit.sv]
// raid0 stripe request splitter: takes one read or write request (start
// sector, sector count) for a raid-0 volume of two or four disks and emits
// one chunk transaction per stripe piece, in address order, each with disk
// index, sector on that disk, length, offset into the request buffer and a
// last flag on the final piece. counts above 4032 are clamped, zero-count
// requests produce nothing. a request of n chunks (1 to 64) occupies the chunk
// walker, which emits one chunk per cycle while the output register is not
// stalled; the next request starts in the cycle after the last chunk of the
// previous one. a two-entry request queue lets new requests be taken
// while chunks are still being emitted, and the output register lets the
// walker run ahead of a stalled consumer by one chunk. disk_shift and
// stripe_shift may be written only while the block is idle.
module raid0_stripe_request_splitter_unit #(
  parameter int unsigned QUEUE_DEPTH = r0ss_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_sector[47:0], sector_count[59:48], zero pad
  input  logic        in_tuser,   // req_type
  // chunk channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // disk_index[1:0], disk_sector[49:2],
                                  // chunk_length[61:50], buffer_offset[73:62], zero pad
  output logic        out_tuser,  // chunk_type
  output logic        out_tlast,  // last_chunk
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [r0ss_pkg::DSHIFT_W-1:0] DISK_SHIFT_RST   = r0ss_pkg::MIN_DISK_SHIFT;
  localparam logic [r0ss_pkg::SSHIFT_W-1:0] STRIPE_SHIFT_RST = r0ss_pkg::MIN_STRIPE_SHIFT;

  logic [r0ss_pkg::DSHIFT_W-1:0] disk_shift_r;
  logic [r0ss_pkg::SSHIFT_W-1:0] stripe_shift_r;
  logic                          cfg_wr;

  r0ss_pkg::req_t push_data, pop_data;
  logic           push_valid, push_ready, pop_ready;
  r0ss_pkg::hs_t  pop_hs;

  // register file, write completes in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_shift_r   <= DISK_SHIFT_RST;
      stripe_shift_r <= STRIPE_SHIFT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        r0ss_pkg::REG_DISK_SHIFT:   disk_shift_r   <= cfg_pwdata[r0ss_pkg::DSHIFT_W-1:0];
        r0ss_pkg::REG_STRIPE_SHIFT: stripe_shift_r <= cfg_pwdata[r0ss_pkg::SSHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      r0ss_pkg::REG_DISK_SHIFT:   cfg_prdata = 32'(disk_shift_r);
      r0ss_pkg::REG_STRIPE_SHIFT: cfg_prdata = 32'(stripe_shift_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // front: accept, clamp count, drop empty requests
  r0ss_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // request queue between front and chunk walker
  r0ss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_hs_o   (pop_hs),
    .pop_ready  (pop_ready)
  );

  // back: walk the request one stripe piece per cycle unless the output stalls
  r0ss_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .disk_shift   (disk_shift_r),
    .stripe_shift (stripe_shift_r),
    .pop_data     (pop_data),
    .pop_hs_i     (pop_hs),
    .pop_ready    (pop_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule
